@@ rtl/utf8dec_pkg.sv @@
// Shared constants, types and helpers for the UTF-8 stream decoder.
package utf8dec_pkg;

    // Field widths
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned CP_W    = 21;
    localparam int unsigned CNT_W   = 3;
    localparam int unsigned PCNT_W  = 2;
    localparam int unsigned ELEN_W  = 3;
    localparam int unsigned NRES_W  = 3;
    localparam int unsigned S_TDATA_W = 8;
    localparam int unsigned M_TDATA_W = 24;

    // Lead and continuation byte classification
    localparam logic [BYTE_W-1:0] ASCII_MASK = 8'h80;
    localparam logic [BYTE_W-1:0] CONT_MASK  = 8'hC0;
    localparam logic [BYTE_W-1:0] CONT_CODE  = 8'h80;
    localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD2_CODE = 8'hC0;
    localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD3_CODE = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'hF8;
    localparam logic [BYTE_W-1:0] LEAD4_CODE = 8'hF0;

    // Payload masks
    localparam logic [BYTE_W-1:0] PAY2_MASK = 8'h1F;
    localparam logic [BYTE_W-1:0] PAY3_MASK = 8'h0F;
    localparam logic [BYTE_W-1:0] PAY4_MASK = 8'h07;
    localparam logic [BYTE_W-1:0] CONT_PAY_MASK = 8'h3F;

    // Sequence lengths
    localparam logic [ELEN_W-1:0] LEN_NONE = 3'd0;
    localparam logic [ELEN_W-1:0] LEN_ONE  = 3'd1;
    localparam logic [ELEN_W-1:0] LEN_TWO  = 3'd2;
    localparam logic [ELEN_W-1:0] LEN_THREE = 3'd3;
    localparam logic [ELEN_W-1:0] LEN_FOUR = 3'd4;

    localparam logic [CP_W-1:0] REPLACEMENT_CP = 21'h00FFFD;

    // Results caused by one input byte: all but the final one are malformed
    typedef struct packed {
        logic [NRES_W-1:0] count;
        logic [CP_W-1:0]   code_point;
        logic [CNT_W-1:0]  byte_count;
        logic              malformed;
    } result_desc_t;

    // Continuation payload of a byte, six bits
    function automatic logic [5:0] cont_payload(input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] masked;
        masked = b & CONT_PAY_MASK;
        return masked[5:0];
    endfunction

endpackage

@@ rtl/utf8dec_decode.sv @@
// Byte classification, pending-sequence state and per-byte result descriptor.
module utf8dec_decode (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                accept,
    input  logic [utf8dec_pkg::BYTE_W-1:0]      in_byte,
    input  logic                                end_of_string,
    output utf8dec_pkg::result_desc_t           desc
);

    logic [utf8dec_pkg::BYTE_W-1:0] pend_reg [3];
    logic [utf8dec_pkg::PCNT_W-1:0] pcount_reg, pcount_next;
    logic [utf8dec_pkg::ELEN_W-1:0] elen_reg, elen_next;

    logic                            is_cont;
    logic                            is_ascii;
    logic [utf8dec_pkg::ELEN_W-1:0]  lead_len;
    logic [utf8dec_pkg::NRES_W-1:0]  flush_a;
    logic [utf8dec_pkg::NRES_W-1:0]  flush_b;
    logic                            head_emit;
    logic [utf8dec_pkg::CP_W-1:0]    head_cp;
    logic [utf8dec_pkg::CNT_W-1:0]   head_cnt;
    logic                            head_bad;
    logic [utf8dec_pkg::PCNT_W-1:0]  pcount_mid;
    logic [utf8dec_pkg::ELEN_W-1:0]  elen_mid;
    logic                            store_lead;
    logic                            store_cont;
    logic [utf8dec_pkg::CP_W-1:0]    assembled;
    logic [utf8dec_pkg::BYTE_W-1:0]  lead2_pay, lead3_pay, lead4_pay;

    // Classify the incoming byte
    always_comb begin
        is_cont  = (in_byte & utf8dec_pkg::CONT_MASK) == utf8dec_pkg::CONT_CODE;
        is_ascii = (in_byte & utf8dec_pkg::ASCII_MASK) == '0;
        priority if ((in_byte & utf8dec_pkg::LEAD2_MASK) == utf8dec_pkg::LEAD2_CODE) begin
            lead_len = utf8dec_pkg::LEN_TWO;
        end else if ((in_byte & utf8dec_pkg::LEAD3_MASK) == utf8dec_pkg::LEAD3_CODE) begin
            lead_len = utf8dec_pkg::LEN_THREE;
        end else if ((in_byte & utf8dec_pkg::LEAD4_MASK) == utf8dec_pkg::LEAD4_CODE) begin
            lead_len = utf8dec_pkg::LEN_FOUR;
        end else begin
            lead_len = utf8dec_pkg::LEN_NONE;
        end
    end

    // Assemble a completed sequence from the held bytes and this byte
    always_comb begin
        lead2_pay = pend_reg[0] & utf8dec_pkg::PAY2_MASK;
        lead3_pay = pend_reg[0] & utf8dec_pkg::PAY3_MASK;
        lead4_pay = pend_reg[0] & utf8dec_pkg::PAY4_MASK;
        unique case (elen_reg)
            utf8dec_pkg::LEN_TWO: begin
                assembled = {10'd0, lead2_pay[4:0], utf8dec_pkg::cont_payload(in_byte)};
            end
            utf8dec_pkg::LEN_THREE: begin
                assembled = {5'd0, lead3_pay[3:0],
                             utf8dec_pkg::cont_payload(pend_reg[1]),
                             utf8dec_pkg::cont_payload(in_byte)};
            end
            default: begin
                assembled = {lead4_pay[2:0],
                             utf8dec_pkg::cont_payload(pend_reg[1]),
                             utf8dec_pkg::cont_payload(pend_reg[2]),
                             utf8dec_pkg::cont_payload(in_byte)};
            end
        endcase
    end

    // Work out the results and the next state for this byte
    always_comb begin
        flush_a    = '0;
        head_emit  = 1'b0;
        head_cp    = utf8dec_pkg::REPLACEMENT_CP;
        head_cnt   = utf8dec_pkg::LEN_ONE;
        head_bad   = 1'b1;
        pcount_mid = pcount_reg;
        elen_mid   = elen_reg;
        store_lead = 1'b0;
        store_cont = 1'b0;

        if (pcount_reg != '0 && is_cont) begin
            // continuation: either complete the sequence or hold the byte
            if ({1'b0, pcount_reg} + 3'd1 >= elen_reg) begin
                head_emit  = 1'b1;
                head_cp    = assembled;
                head_cnt   = elen_reg;
                head_bad   = 1'b0;
                pcount_mid = '0;
                elen_mid   = utf8dec_pkg::LEN_NONE;
            end else begin
                store_cont = 1'b1;
                pcount_mid = pcount_reg + 2'd1;
            end
        end else begin
            // drop a broken sequence, then treat the byte as a lead
            if (pcount_reg != '0) begin
                flush_a = {1'b0, pcount_reg};
            end
            pcount_mid = '0;
            elen_mid   = utf8dec_pkg::LEN_NONE;
            if (is_ascii) begin
                head_emit = 1'b1;
                head_cp   = {13'd0, in_byte};
                head_bad  = 1'b0;
            end else if (lead_len == utf8dec_pkg::LEN_NONE) begin
                head_emit = 1'b1;
            end else begin
                store_lead = 1'b1;
                pcount_mid = 2'd1;
                elen_mid   = lead_len;
            end
        end

        // end of string drops whatever is still held
        flush_b     = '0;
        pcount_next = pcount_mid;
        elen_next   = elen_mid;
        if (end_of_string && pcount_mid != '0) begin
            flush_b     = {1'b0, pcount_mid};
            pcount_next = '0;
            elen_next   = utf8dec_pkg::LEN_NONE;
        end

        desc.count      = flush_a + flush_b + {2'b00, head_emit};
        desc.code_point = head_emit ? head_cp : utf8dec_pkg::REPLACEMENT_CP;
        desc.byte_count = head_emit ? head_cnt : utf8dec_pkg::LEN_ONE;
        desc.malformed  = head_emit ? head_bad : 1'b1;
    end

    // Advance the sequence state on each accepted beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pcount_reg <= '0;
            elen_reg   <= utf8dec_pkg::LEN_NONE;
        end else if (accept) begin
            pcount_reg <= pcount_next;
            elen_reg   <= elen_next;
        end
    end

    // Hold lead and continuation bytes
    always_ff @(posedge aclk) begin
        if (accept && store_lead) begin
            pend_reg[0] <= in_byte;
        end
        if (accept && store_cont && pcount_reg == 2'd1) begin
            pend_reg[1] <= in_byte;
        end
        if (accept && store_cont && pcount_reg == 2'd2) begin
            pend_reg[2] <= in_byte;
        end
    end

endmodule

@@ rtl/utf8dec_emit.sv @@
// Result register: plays out the results of one byte, one beat per cycle while m_tready is high.
module utf8dec_emit (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  load,
    input  utf8dec_pkg::result_desc_t             desc,
    output logic                                  can_load,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [utf8dec_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic                                  m_tlast,
    output logic                                  m_tuser
);

    logic [utf8dec_pkg::NRES_W-1:0] remain_reg, remain_next;
    logic [utf8dec_pkg::CP_W-1:0]   cp_reg;
    logic [utf8dec_pkg::CNT_W-1:0]  cnt_reg;
    logic                           bad_reg;
    logic                           final_beat;

    assign final_beat = remain_reg == 3'd1;
    assign m_tvalid   = remain_reg != '0;
    assign m_tlast    = final_beat;
    assign can_load   = (remain_reg == '0) || (final_beat && m_tready);

    // Earlier beats are replacement results; the last carries the final fields
    assign m_tdata = final_beat ? {cnt_reg, cp_reg}
                                : {utf8dec_pkg::LEN_ONE, utf8dec_pkg::REPLACEMENT_CP};
    assign m_tuser = final_beat ? bad_reg : 1'b1;

    // Count down the beats still owed
    always_comb begin
        remain_next = remain_reg;
        if (load) begin
            remain_next = desc.count;
        end else if (m_tvalid && m_tready) begin
            remain_next = remain_reg - 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            remain_reg <= '0;
        end else begin
            remain_reg <= remain_next;
        end
    end

    // Hold the final result fields
    always_ff @(posedge aclk) begin
        if (load) begin
            cp_reg  <= desc.code_point;
            cnt_reg <= desc.byte_count;
            bad_reg <= desc.malformed;
        end
    end

endmodule

@@ rtl/utf8_stream_decoder_core.sv @@
// UTF-8 stream decoder: top level joining the decode stage and result register.
//
// Input channel s_*: one raw byte a beat in s_tdata[7:0]; s_tlast marks the
// last byte of a string. Output channel m_*: one decoded result a beat,
// m_tdata holds the code point and the byte count, m_tuser flags a
// malformed result (code point U+FFFD) and m_tlast marks the final result
// caused by one input byte.
// A byte is decoded in the cycle it is accepted and its results appear from
// the next cycle on. A byte that completes or breaks nothing gives no
// result. One byte is taken every cycle as long as each gives at most one
// result and the receiver is ready; a byte that flushes a broken or truncated
// sequence gives up to four results, and s_tready stays low until the
// result register is on its last beat, so the next byte waits until all
// but the last of those results have been taken.
// When the receiver stalls, the current result is held on m_* and s_tready
// drops once the result register cannot take the next byte's results.
// Reset (aresetn low at a clock edge) clears the held sequence and drops
// any results not yet delivered.
module utf8_stream_decoder_core (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [utf8dec_pkg::S_TDATA_W-1:0]     s_tdata,  // [7:0] in_byte
    input  logic                                  s_tlast,  // end_of_string
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [utf8dec_pkg::M_TDATA_W-1:0]     m_tdata,  // [20:0] code_point, [23:21] byte_count
    output logic                                  m_tlast,  // run_last
    output logic                                  m_tuser   // [0] malformed
);

    utf8dec_pkg::result_desc_t desc;
    logic                      can_load;
    logic                      accept;

    assign s_tready = can_load;
    assign accept   = s_tvalid && s_tready;

    utf8dec_decode u_decode (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .accept        (accept),
        .in_byte       (s_tdata[7:0]),
        .end_of_string (s_tlast),
        .desc          (desc)
    );

    utf8dec_emit u_emit (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (accept),
        .desc     (desc),
        .can_load (can_load),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

@@ rtl/utf8dec_checker.sv @@
// Port-level checks for the UTF-8 stream decoder, bound to the top level.
module utf8dec_checker (
    input logic                                  aclk,
    input logic                                  aresetn,
    input logic                                  s_tready,
    input logic                                  m_tvalid,
    input logic                                  m_tready,
    input logic [utf8dec_pkg::M_TDATA_W-1:0]     m_tdata,
    input logic                                  m_tlast,
    input logic                                  m_tuser
);

    // A stalled result beat holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
    else $error("stalled result beat changed");

    // Malformed results carry the replacement code point and count one
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |->
            m_tdata[20:0] == utf8dec_pkg::REPLACEMENT_CP && m_tdata[23:21] == 3'd1)
    else $error("malformed result with wrong fields");

    // Well-formed results consumed one to four bytes
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[23:21] != 3'd0 && m_tdata[23:21] <= 3'd4)
    else $error("well-formed result with bad byte count");

    // Only the final result of a byte may be well formed
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> m_tuser)
    else $error("well-formed result before the final one");

    // Input stalls only while results are pending
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
    else $error("input stalled with no result pending");

endmodule

bind utf8_stream_decoder_core utf8dec_checker u_utf8dec_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);
